// ===== hw/rtl/rv32_pkg.sv =====
// Shared types, constants and decode codes for the RV32I step core.
package rv32_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int MEM_WORDS = MEM_BYTES / 4;
    localparam int WORD_AW   = MEM_AW - 2;

    localparam logic [31:0] SP_RESET = 32'h8000_0000;

    localparam logic [0:0] CFG_RESET_PC = 1'b0;
    localparam logic [0:0] CFG_SP       = 1'b1;

    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_FENCE  = 7'h0f;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    typedef struct packed {
        logic        status;
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        store_valid;
        logic [31:0] store_address;
        logic [31:0] store_data;
        logic [1:0]  store_size;
        logic [63:0] retired_count;
    } result_t;

    function automatic logic [31:0] sext12(input logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

endpackage

// ===== hw/rtl/rv32_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rv32_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/rv32i_instruction_step.sv =====
// Top level: RV32I step core with byte-lane data memory and register file.
// A load item's result is registered. A step passes through the fetch read and
// register read, decode and address, and execute and write back states; a data
// load adds a memory read state. One item in flight: a step holds off the
// input until it commits; load items go back to back while the result side is free.
// Reset (aresetn low, synchronous) sets pc to zero, x2 to the stack
// pointer reset value, clears the count; memory contents are undefined.
module rv32i_instruction_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [15:0] s_load_address,
    input  logic [7:0]  s_load_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [31:0] m_next_pc,
    output logic        m_reg_written,
    output logic [4:0]  m_reg_index,
    output logic [31:0] m_reg_value,
    output logic        m_store_valid,
    output logic [31:0] m_store_address,
    output logic [31:0] m_store_data,
    output logic [1:0]  m_store_size,
    output logic [63:0] m_retired_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import rv32_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_DEC   = 5'b00100,
        ST_MEM1  = 5'b01000,
        ST_EXEC  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] pc_reg;
    logic [63:0] cnt_reg;
    logic [31:0] rf_reg [32];
    logic [31:0] inst_reg;
    logic [31:0] ld_lo_reg;
    logic [31:0] ea_reg;
    logic [31:0] a_reg, b_reg;
    result_t     res_reg;
    logic        mv_reg;

    // four byte-lane memories, word addressed
    logic [3:0]         lane_we;
    logic [WORD_AW-1:0] lane_waddr [4];
    logic [7:0]         lane_wdata [4];
    logic [WORD_AW-1:0] lane_raddr [4];
    logic [7:0]         lane_rdata [4];
    logic [31:0]        rword;
    logic [MEM_AW-1:0]  rd_base;

    for (genvar g = 0; g < 4; g++) begin : g_lane
        rv32_ram #(.WIDTH(8), .DEPTH(MEM_WORDS)) u_ram (
            .aclk (aclk),
            .we   (lane_we[g]),
            .waddr(lane_waddr[g]),
            .wdata(lane_wdata[g]),
            .raddr(lane_raddr[g]),
            .rdata(lane_rdata[g])
        );
    end

    // byte i of the read = lane (base+i)%4 ; rotate back
    logic [1:0] rot_reg;
    always_comb begin
        logic [31:0] raw;
        raw = {lane_rdata[3], lane_rdata[2], lane_rdata[1], lane_rdata[0]};
        rword = 32'((raw >> {rot_reg, 3'b000}) | (raw << (6'd32 - {rot_reg, 3'b000})));
        if (rot_reg == 2'd0) rword = raw;
    end

    // lanes below the start lane hold bytes of the next word row
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            lane_raddr[i] = rd_base[MEM_AW-1:2] +
                            ((2'(i) < rd_base[1:0]) ? WORD_AW'(1) : WORD_AW'(0));
        end
    end

    // decode
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd, rs1, rs2;
    logic [31:0] immi, imms, immb, immj;
    assign op  = inst_reg[6:0];
    assign rd  = inst_reg[11:7];
    assign f3  = inst_reg[14:12];
    assign rs1 = inst_reg[19:15];
    assign rs2 = inst_reg[24:20];
    assign f7  = inst_reg[31:25];
    assign immi = sext12(inst_reg[31:20]);
    assign imms = sext12({inst_reg[31:25], inst_reg[11:7]});
    assign immb = {{20{inst_reg[31]}}, inst_reg[7], inst_reg[30:25], inst_reg[11:8], 1'b0};
    assign immj = {{12{inst_reg[31]}}, inst_reg[19:12], inst_reg[20], inst_reg[30:21], 1'b0};

    logic [31:0] ea_calc;
    assign ea_calc = a_reg + (op == OP_STORE ? imms : immi);

    // execute
    logic        ill, wr, st, take;
    logic [31:0] rdv, npc, sdat, ldv;
    always_comb begin
        ill = 1'b0; wr = 1'b0; st = 1'b0; take = 1'b0;
        rdv = '0; sdat = '0;
        npc = pc_reg + 32'd4;
        ldv = rword;
        case (f3)
            3'd0: ldv = {{24{ld_lo_reg[7]}}, ld_lo_reg[7:0]};
            3'd1: ldv = {{16{ld_lo_reg[15]}}, ld_lo_reg[15:0]};
            3'd4: ldv = {24'd0, ld_lo_reg[7:0]};
            3'd5: ldv = {16'd0, ld_lo_reg[15:0]};
            default: ldv = ld_lo_reg;
        endcase
        case (op)
            OP_LOAD: begin
                wr = 1'b1; rdv = ldv;
                if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) ill = 1'b1;
            end
            OP_FENCE, OP_SYSTEM: ;
            OP_IMM: begin
                wr = 1'b1;
                case (f3)
                    3'd0: rdv = a_reg + immi;
                    3'd1: if (f7 == 7'd0) rdv = a_reg << rs2; else ill = 1'b1;
                    3'd2: rdv = {31'd0, $signed(a_reg) < $signed(immi)};
                    3'd3: rdv = {31'd0, a_reg < immi};
                    3'd4: rdv = a_reg ^ immi;
                    3'd5: if (f7 == 7'd0) rdv = a_reg >> rs2;
                          else if (f7 == 7'd32) rdv = 32'($signed(a_reg) >>> rs2);
                          else ill = 1'b1;
                    3'd6: rdv = a_reg | immi;
                    default: rdv = a_reg & immi;
                endcase
            end
            OP_STORE: begin
                if (f3 > 3'd2) ill = 1'b1;
                st = 1'b1;
                case (f3[1:0])
                    SZ_BYTE: sdat = {24'd0, b_reg[7:0]};
                    SZ_HALF: sdat = {16'd0, b_reg[15:0]};
                    default: sdat = b_reg;
                endcase
            end
            OP_LUI:   begin wr = 1'b1; rdv = {inst_reg[31:12], 12'd0}; end
            OP_AUIPC: begin wr = 1'b1; rdv = pc_reg + {inst_reg[31:12], 12'd0}; end
            OP_JALR: begin
                if (f3 != 3'd0) ill = 1'b1;
                wr = 1'b1; rdv = pc_reg + 32'd4;
                npc = {ea_reg[31:1], 1'b0};
            end
            OP_JAL: begin
                wr = 1'b1; rdv = pc_reg + 32'd4;
                npc = pc_reg + immj;
            end
            OP_REG: begin
                wr = 1'b1;
                if (f3 == 3'd0 && f7 == 7'd32) rdv = a_reg - b_reg;
                else if (f7 != 7'd0) ill = 1'b1;
                else case (f3)
                    3'd0: rdv = a_reg + b_reg;
                    3'd1: rdv = a_reg << b_reg[4:0];
                    3'd3: rdv = {31'd0, a_reg < b_reg};
                    3'd4: rdv = a_reg ^ b_reg;
                    3'd6: rdv = a_reg | b_reg;
                    3'd7: rdv = a_reg & b_reg;
                    default: ill = 1'b1;
                endcase
            end
            OP_BRANCH: begin
                case (f3)
                    3'd0: take = a_reg == b_reg;
                    3'd1: take = a_reg != b_reg;
                    3'd4: take = $signed(a_reg) < $signed(b_reg);
                    3'd5: take = $signed(a_reg) >= $signed(b_reg);
                    3'd6: take = a_reg < b_reg;
                    3'd7: take = a_reg >= b_reg;
                    default: ill = 1'b1;
                endcase
                if (take) npc = pc_reg + immb;
            end
            default: ill = 1'b1;
        endcase
    end

    logic out_free, s_fire, cfg_fire, commit;
    assign out_free  = !mv_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign commit    = (state_reg == ST_EXEC) && out_free;

    // memory port control; each lane gets its own address, so one read
    // covers any 4 consecutive bytes
    always_comb begin
        logic [31:0] sa;
        logic [MEM_AW-1:0] b;
        sa = '0;
        b  = '0;
        lane_we = '0;
        for (int i = 0; i < 4; i++) begin
            lane_waddr[i] = '0;
            lane_wdata[i] = '0;
        end
        rd_base = pc_reg[MEM_AW-1:0];
        if (state_reg == ST_DEC) rd_base = ea_calc[MEM_AW-1:0];
        if (s_fire && !s_operation) begin
            b = MEM_AW'(s_load_address);
            lane_we[b[1:0]] = 1'b1;
            lane_waddr[b[1:0]] = b[MEM_AW-1:2];
            lane_wdata[b[1:0]] = s_load_byte;
        end else if (commit && st && !ill) begin
            sa = ea_reg;
            for (int i = 0; i < 4; i++) begin
                b = sa[MEM_AW-1:0] + MEM_AW'(i);
                if (i < (1 << f3[1:0])) begin
                    lane_we[b[1:0]] = 1'b1;
                    lane_waddr[b[1:0]] = b[MEM_AW-1:2];
                    lane_wdata[b[1:0]] = sdat[8*i +: 8];
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_fire && s_operation) state_next = ST_FETCH;
            ST_FETCH: state_next = ST_DEC;
            ST_DEC:   state_next = (op == OP_LOAD) ? ST_MEM1 : ST_EXEC;
            ST_MEM1:  state_next = ST_EXEC;
            ST_EXEC:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
            for (int i = 0; i < 32; i++) rf_reg[i] <= (i == 2) ? SP_RESET : 32'd0;
        end else begin
            state_reg <= state_next;
            if ((s_fire && !s_operation) || commit) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
            if (cfg_fire) begin
                if (cfg_index == CFG_RESET_PC) pc_reg <= cfg_data;
                else rf_reg[2] <= cfg_data;
            end
            if (s_fire && !s_operation) begin
                res_reg <= '{status: 1'b0, next_pc: pc_reg, reg_written: 1'b0,
                             reg_index: '0, reg_value: '0, store_valid: 1'b0,
                             store_address: '0, store_data: '0, store_size: '0,
                             retired_count: cnt_reg};
            end
            rot_reg <= rd_base[1:0];
            // operands come straight from the fetched word
            if (state_reg == ST_FETCH) begin
                inst_reg <= rword;
                a_reg    <= rf_reg[rword[19:15]];
                b_reg    <= rf_reg[rword[24:20]];
            end
            if (state_reg == ST_DEC) ea_reg <= ea_calc;
            if (state_reg == ST_MEM1) ld_lo_reg <= rword;
            if (commit) begin
                if (ill) begin
                    res_reg <= '{status: 1'b1, next_pc: pc_reg, reg_written: 1'b0,
                                 reg_index: '0, reg_value: '0, store_valid: 1'b0,
                                 store_address: '0, store_data: '0, store_size: '0,
                                 retired_count: cnt_reg};
                end else begin
                    pc_reg  <= npc;
                    cnt_reg <= cnt_reg + 64'd1;
                    if (wr && rd != 5'd0) rf_reg[rd] <= rdv;
                    res_reg <= '{status: 1'b0, next_pc: npc,
                                 reg_written: wr && rd != 5'd0,
                                 reg_index: (wr && rd != 5'd0) ? rd : 5'd0,
                                 reg_value: (wr && rd != 5'd0) ? rdv : 32'd0,
                                 store_valid: st,
                                 store_address: st ? ea_reg : 32'd0,
                                 store_data: sdat,
                                 store_size: st ? f3[1:0] : 2'd0,
                                 retired_count: cnt_reg + 64'd1};
                end
            end
        end
    end

    assign m_valid         = mv_reg;
    assign m_status        = res_reg.status;
    assign m_next_pc       = res_reg.next_pc;
    assign m_reg_written   = res_reg.reg_written;
    assign m_reg_index     = res_reg.reg_index;
    assign m_reg_value     = res_reg.reg_value;
    assign m_store_valid   = res_reg.store_valid;
    assign m_store_address = res_reg.store_address;
    assign m_store_data    = res_reg.store_data;
    assign m_store_size    = res_reg.store_size;
    assign m_retired_count = res_reg.retired_count;

    a_x0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_reg[0] == 32'd0) else $error("x0 written");
    a_one_hot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && !ill |=> cnt_reg == $past(cnt_reg) + 64'd1) else $error("count");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && !m_ready |=> $stable(res_reg)) else $error("result changed");
endmodule

// ===== tb/rv32_tb_codes_pkg.sv =====
// Instruction field codes shared by the stimulus and the checker.
package rv32_tb_codes_pkg;

    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;

    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_SH   = 3'd1;
    localparam logic [2:0] F3_SW   = 3'd2;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_ALT  = 7'd32;

    localparam logic ITEM_LOAD = 1'b0;
    localparam logic ITEM_STEP = 1'b1;

endpackage

// ===== tb/rv32i_instruction_step_checker.sv =====
// Channel monitor, core predictor and result comparator for the RV32I step core.
module rv32i_instruction_step_checker
    import rv32_pkg::*;
    import rv32_tb_codes_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_operation,
    input  logic [15:0] s_load_address,
    input  logic [7:0]  s_load_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_status,
    input  logic [31:0] m_next_pc,
    input  logic        m_reg_written,
    input  logic [4:0]  m_reg_index,
    input  logic [31:0] m_reg_value,
    input  logic        m_store_valid,
    input  logic [31:0] m_store_address,
    input  logic [31:0] m_store_data,
    input  logic [1:0]  m_store_size,
    input  logic [63:0] m_retired_count,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  core_mem [MEM_BYTES];
    logic [31:0] core_regs [32];
    logic [31:0] core_pc;
    logic [63:0] core_retired;
    result_t     expected_results[$];

    initial begin
        foreach (core_mem[i]) core_mem[i] = 8'h00;
    end

    assign pending = expected_results.size();

    function automatic logic [31:0] mem_fetch(input logic [31:0] addr, input int nbytes);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < nbytes; i++) v[8*i +: 8] = core_mem[(addr + i) % MEM_BYTES];
        return v;
    endfunction

    task automatic execute_item(input logic op, input logic [15:0] la, input logic [7:0] lb,
                                output result_t r);
        logic [31:0] ins, a, b, immi, imms, rdv, npc, sa, sd, ldw;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic        bad, wr, st, take;
        r = '0;
        if (op == ITEM_LOAD) begin
            core_mem[la] = lb;
            r.next_pc = core_pc;
            r.retired_count = core_retired;
            return;
        end
        ins  = mem_fetch(core_pc, 4);
        rd   = ins[11:7];
        f3   = ins[14:12];
        rs1  = ins[19:15];
        rs2  = ins[24:20];
        f7   = ins[31:25];
        a    = core_regs[rs1];
        b    = core_regs[rs2];
        immi = {{20{ins[31]}}, ins[31:20]};
        imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        npc  = core_pc + 32'd4;
        rdv  = '0;
        sa   = '0;
        sd   = '0;
        ldw  = '0;
        bad  = 1'b0;
        wr   = 1'b0;
        st   = 1'b0;
        take = 1'b0;
        case (ins[6:0])
            OP_LOAD: begin
                wr = 1'b1;
                case (f3)
                    F3_LB: begin
                        ldw = mem_fetch(a + immi, 1);
                        rdv = {{24{ldw[7]}}, ldw[7:0]};
                    end
                    F3_LH: begin
                        ldw = mem_fetch(a + immi, 2);
                        rdv = {{16{ldw[15]}}, ldw[15:0]};
                    end
                    F3_LW:   rdv = mem_fetch(a + immi, 4);
                    F3_LBU:  rdv = mem_fetch(a + immi, 1);
                    F3_LHU:  rdv = mem_fetch(a + immi, 2);
                    default: bad = 1'b1;
                endcase
            end
            OP_FENCE, OP_SYSTEM: ;
            OP_IMM: begin
                wr = 1'b1;
                case (f3)
                    F3_ADD:  rdv = a + immi;
                    F3_SLL:  if (f7 == F7_BASE) rdv = a << rs2; else bad = 1'b1;
                    F3_SLT:  rdv = {31'd0, $signed(a) < $signed(immi)};
                    F3_SLTU: rdv = {31'd0, a < immi};
                    F3_XOR:  rdv = a ^ immi;
                    F3_SR: begin
                        if (f7 == F7_BASE) rdv = a >> rs2;
                        else if (f7 == F7_ALT) rdv = $signed(a) >>> rs2;
                        else bad = 1'b1;
                    end
                    F3_OR:   rdv = a | immi;
                    default: rdv = a & immi;
                endcase
            end
            OP_STORE: begin
                if (f3 > F3_SW) bad = 1'b1;
                else begin
                    st = 1'b1;
                    sa = a + imms;
                    sd = (f3 == F3_SB) ? (b & 32'hff) : (f3 == F3_SH) ? (b & 32'hffff) : b;
                end
            end
            OP_LUI: begin
                wr = 1'b1;
                rdv = {ins[31:12], 12'd0};
            end
            OP_AUIPC: begin
                wr = 1'b1;
                rdv = core_pc + {ins[31:12], 12'd0};
            end
            OP_JALR: begin
                if (f3 != F3_ADD) bad = 1'b1;
                else begin
                    wr = 1'b1;
                    rdv = core_pc + 32'd4;
                    npc = (a + immi) & ~32'd1;
                end
            end
            OP_JAL: begin
                wr = 1'b1;
                rdv = core_pc + 32'd4;
                npc = core_pc + {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
            end
            OP_REG: begin
                wr = 1'b1;
                if (f3 == F3_ADD && f7 == F7_ALT) rdv = a - b;
                else if (f7 != F7_BASE) bad = 1'b1;
                else case (f3)
                    F3_ADD:  rdv = a + b;
                    F3_SLL:  rdv = a << b[4:0];
                    F3_SLTU: rdv = {31'd0, a < b};
                    F3_XOR:  rdv = a ^ b;
                    F3_OR:   rdv = a | b;
                    F3_AND:  rdv = a & b;
                    default: bad = 1'b1;
                endcase
            end
            OP_BRANCH: begin
                case (f3)
                    F3_BEQ:  take = (a == b);
                    F3_BNE:  take = (a != b);
                    F3_BLT:  take = $signed(a) < $signed(b);
                    F3_BGE:  take = !($signed(a) < $signed(b));
                    F3_BLTU: take = a < b;
                    F3_BGEU: take = a >= b;
                    default: bad = 1'b1;
                endcase
                if (take) npc = core_pc + {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            r.status = 1'b1;
            r.next_pc = core_pc;
            r.retired_count = core_retired;
            return;
        end
        if (st)
            for (int i = 0; i < (1 << f3); i++) core_mem[(sa + i) % MEM_BYTES] = sd[8*i +: 8];
        if (wr && rd != 5'd0) begin
            core_regs[rd] = rdv;
            r.reg_written = 1'b1;
            r.reg_index = rd;
            r.reg_value = rdv;
        end
        core_pc = npc;
        core_retired++;
        r.next_pc = npc;
        if (st) begin
            r.store_valid = 1'b1;
            r.store_address = sa;
            r.store_data = sd;
            r.store_size = f3[1:0];
        end
        r.retired_count = core_retired;
    endtask

    task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
        if (e !== a) begin
            $display("%0t ns: %s expected %h actual %h", $time, name, e, a);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t r, e;
        if (!aresetn) begin
            foreach (core_regs[i]) core_regs[i] = '0;
            core_regs[2] = SP_RESET;
            core_pc = '0;
            core_retired = '0;
            mismatches = 0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_RESET_PC) core_pc = cfg_data;
                else core_regs[2] = cfg_data;
            end
            if (s_valid && s_ready) begin
                execute_item(s_operation, s_load_address, s_load_byte, r);
                expected_results.push_back(r);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result transaction with nothing expected, next_pc %h",
                             $time, m_next_pc);
                    mismatches++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("status", e.status, m_status);
                    check_field("next_pc", e.next_pc, m_next_pc);
                    check_field("reg_written", e.reg_written, m_reg_written);
                    check_field("reg_index", e.reg_index, m_reg_index);
                    check_field("reg_value", e.reg_value, m_reg_value);
                    check_field("store_valid", e.store_valid, m_store_valid);
                    check_field("store_address", e.store_address, m_store_address);
                    check_field("store_data", e.store_data, m_store_data);
                    check_field("store_size", e.store_size, m_store_size);
                    check_field("retired_count", e.retired_count, m_retired_count);
                end
            end
        end
    end

endmodule

// ===== tb/rv32i_instruction_step_test.sv =====
// Stimulus and verdict for the RV32I step core; checking is done by the checker.
module rv32i_instruction_step_test;
    import rv32_pkg::*;
    import rv32_tb_codes_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = ITEM_LOAD;
    logic [15:0] s_load_address = '0;
    logic [7:0]  s_load_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_status;
    logic [31:0] m_next_pc;
    logic        m_reg_written;
    logic [4:0]  m_reg_index;
    logic [31:0] m_reg_value;
    logic        m_store_valid;
    logic [31:0] m_store_address;
    logic [31:0] m_store_data;
    logic [1:0]  m_store_size;
    logic [63:0] m_retired_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = CFG_RESET_PC;
    logic [31:0] cfg_data = '0;
    int          mismatches;
    int          pending;

    rv32i_instruction_step i_dut (.*);
    rv32i_instruction_step_checker i_checker (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Architectural view rebuilt from observed transactions; steers the stimulus only.
    logic [31:0] seen_regs [32];
    logic [31:0] seen_pc;
    bit          byte_written [MEM_BYTES];
    int          items_sent, results_seen, steps_sent, illegal_seen, stores_seen, cfg_writes;
    logic        s_fire, cfg_fire;
    bit          calm, hold_req;

    always @(posedge aclk) begin
        s_fire   <= s_valid && s_ready;
        cfg_fire <= cfg_valid && cfg_ready;
        if (!aresetn) begin
            foreach (seen_regs[i]) seen_regs[i] = '0;
            seen_regs[2] = SP_RESET;
            seen_pc = '0;
            results_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_RESET_PC) seen_pc = cfg_data;
                else seen_regs[2] = cfg_data;
            end
            if (s_valid && s_ready && s_operation == ITEM_LOAD)
                byte_written[s_load_address] = 1'b1;
            if (m_valid && m_ready) begin
                results_seen++;
                seen_pc = m_next_pc;
                if (m_status) illegal_seen++;
                if (m_reg_written) seen_regs[m_reg_index] = m_reg_value;
                if (m_store_valid) begin
                    stores_seen++;
                    for (int i = 0; i < (1 << m_store_size); i++)
                        byte_written[(m_store_address + i) % MEM_BYTES] = 1'b1;
                end
            end
        end
    end

    // Result side back-pressure, with one long hold-off on request.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready = 1'b0;
                for (int n = 0; n < 150; n++) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    task automatic send_item(input logic op, input logic [15:0] la, input logic [7:0] lb);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_operation = op;
        s_load_address = la;
        s_load_byte = lb;
        do @(negedge aclk); while (!s_fire);
        s_valid = 1'b0;
        items_sent++;
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [31:0] val);
        while (pending != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [4:0] rs1,
                                          input logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [4:0] rs1,
                                          input logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] rand_instruction();
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [11:0] imm;
        logic [12:0] boff;
        logic [20:0] joff;
        logic [6:0]  f7;
        rd   = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
        rs1  = 5'($urandom_range(0, 31));
        rs2  = 5'($urandom_range(0, 31));
        f3   = 3'($urandom_range(0, 7));
        imm  = 12'($urandom);
        boff = {5'($urandom_range(0, 31)) - 5'd16, 7'($urandom), 1'b0};
        joff = {$urandom_range(0, 1) ? 13'h1fff : 13'h0, 7'($urandom), 1'b0};
        case ($urandom_range(0, 3))
            0:       f7 = 7'($urandom);
            1:       f7 = F7_ALT;
            default: f7 = F7_BASE;
        endcase
        case ($urandom_range(0, 13))
            0:       return {20'($urandom), rd, OP_LUI};
            1:       return {20'($urandom), rd, OP_AUIPC};
            2:       return {joff[20], joff[10:1], joff[11], joff[19:12], rd, OP_JAL};
            3:       return enc_i(OP_JALR, ($urandom_range(0, 4) == 0) ? f3 : F3_ADD, rd, rs1, imm);
            4:       return {boff[12], boff[10:5], rs2, rs1, f3, boff[4:1], boff[11], OP_BRANCH};
            5, 6:    return enc_i(OP_LOAD, f3, rd, rs1, imm);
            7:       return enc_s(($urandom_range(0, 3) == 0) ? f3 : 3'($urandom_range(0, 2)),
                                  rs1, rs2, imm);
            8, 9:    return (f3 == F3_SLL || f3 == F3_SR) ? {f7, rs2, rs1, f3, rd, OP_IMM}
                                                         : enc_i(OP_IMM, f3, rd, rs1, imm);
            10, 11:  return enc_r(f7, f3, rd, rs1, rs2);
            12:      return {25'($urandom), ($urandom_range(0, 1) != 0) ? OP_FENCE : OP_SYSTEM};
            default: return $urandom;
        endcase
    endfunction

    // Place the instruction (and any bytes a load may read) in memory, then step.
    task automatic run_instruction(input logic [31:0] ins);
        logic [31:0] base;
        if (ins[6:0] == OP_LOAD) begin
            base = seen_regs[ins[19:15]] + {{20{ins[31]}}, ins[31:20]};
            for (int i = 0; i < 4; i++)
                if (!byte_written[(base + i) % MEM_BYTES])
                    send_item(ITEM_LOAD, 16'((base + i) % MEM_BYTES), 8'($urandom));
        end
        for (int i = 0; i < 4; i++)
            send_item(ITEM_LOAD, 16'((seen_pc + i) % MEM_BYTES), ins[8*i +: 8]);
        send_item(ITEM_STEP, 16'($urandom), 8'($urandom));
        steps_sent++;
        while (results_seen != items_sent) @(negedge aclk);
    endtask

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [31:0] pc_choice [4];
        logic [31:0] sp_choice [4];
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: address and byte extremes, then the notable instructions.
        send_item(ITEM_LOAD, 16'hffff, 8'hff);
        send_item(ITEM_LOAD, 16'h0000, 8'h00);
        run_instruction({20'hfffff, 5'd1, OP_LUI});
        run_instruction(enc_i(OP_IMM, F3_ADD, 5'd0, 5'd1, 12'h7ff));
        run_instruction(enc_i(OP_IMM, F3_SLTU, 5'd3, 5'd1, 12'hfff));
        run_instruction(enc_r(F7_ALT, F3_SR, 5'd4, 5'd1, 5'd2));
        run_instruction(enc_r(F7_ALT, F3_ADD, 5'd5, 5'd0, 5'd1));
        run_instruction(enc_i(OP_LOAD, F3_LB, 5'd6, 5'd0, 12'hfff));
        run_instruction(enc_s(F3_SW, 5'd0, 5'd1, 12'h800));

        pc_choice = '{32'h0, 32'hffff_fffe, 32'h0000_1000, $urandom};
        sp_choice = '{SP_RESET, 32'hffff_ffff, 32'h0, $urandom};
        for (int phase = 0; phase < 4; phase++) begin
            if (phase > 0) begin
                write_cfg(CFG_RESET_PC, pc_choice[phase]);
                write_cfg(CFG_SP, sp_choice[phase]);
            end
            for (int n = 0; n < 36; n++) begin
                if (phase == 3 && n == 30) calm = 1'b1;
                if (phase == 1 && n == 10) begin
                    // long result hold-off while loads keep coming
                    hold_req = 1'b1;
                    for (int k = 0; k < 20; k++)
                        send_item(ITEM_LOAD, 16'($urandom), 8'($urandom));
                end
                if ($urandom_range(0, 9) == 0)
                    send_item(ITEM_LOAD, 16'($urandom), 8'($urandom));
                run_instruction(rand_instruction());
            end
        end

        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        $display("Ran %0d transactions: %0d executed instructions (%0d illegal, %0d stores),",
                 items_sent, steps_sent, illegal_seen, stores_seen);
        $display("the rest memory byte writes, across %0d register writes.", cfg_writes);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
